FILE: src/afrc_pkg.sv
// ----------------------------------------------------------------------------
// afrc_pkg: shared types and constants of the API frame receiver
// Frame layout constants, the per-frame tracking state and the result item.
// ----------------------------------------------------------------------------
package afrc_pkg;

  localparam int MAX_FRAME = 128;
  localparam int POS_W     = $clog2(MAX_FRAME);
  localparam int BYTE_W    = 8;
  localparam int TOTAL_W   = 9;

  localparam logic [BYTE_W-1:0]  DELIMITER   = 8'h7E;
  localparam logic [BYTE_W-1:0]  LEN_HIGH    = 8'h00;
  localparam logic [BYTE_W-1:0]  TYPE_RESET  = 8'h10;
  localparam logic [BYTE_W-1:0]  CHECK_BASE  = 8'hFF;
  localparam logic [POS_W-1:0]   POS_TYPE    = POS_W'(3);
  localparam logic [TOTAL_W-1:0] FRAME_EXTRA = TOTAL_W'(4);

  typedef struct packed {
    logic [BYTE_W-1:0]  hist0;
    logic [BYTE_W-1:0]  hist1;
    logic [BYTE_W-1:0]  hist2;
    logic [POS_W-1:0]   pos;
    logic [TOTAL_W-1:0] total;
    logic [BYTE_W-1:0]  sum;
    logic [BYTE_W-1:0]  type_byte;
  } frame_state_t;

  typedef struct packed {
    logic               frame_end;
    logic               frame_valid;
    logic [TOTAL_W-1:0] frame_bytes;
    logic [POS_W-1:0]   byte_position;
    logic [BYTE_W-1:0]  computed_check;
  } frame_result_t;

endpackage

FILE: src/afrc_step.sv
// ----------------------------------------------------------------------------
// afrc_step: frame tracking logic for one received byte
// Computes the next tracking state and the result item from the current
// state, the received byte and the expected frame type.
// ----------------------------------------------------------------------------
module afrc_step (
  input  afrc_pkg::frame_state_t       state_i,
  input  logic [afrc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [afrc_pkg::BYTE_W-1:0]  expected_type,
  output afrc_pkg::frame_state_t       state_o,
  output afrc_pkg::frame_result_t      result_o
);

  logic                          resync;
  logic [afrc_pkg::POS_W-1:0]    pos;
  logic                          at_type;
  logic [afrc_pkg::BYTE_W-1:0]   prev_sum;
  logic [afrc_pkg::BYTE_W-1:0]   sum_new;
  logic [afrc_pkg::TOTAL_W-1:0]  total;
  logic [afrc_pkg::POS_W:0]      next_pos;
  logic                          frame_done;
  logic                          at_limit;
  logic [afrc_pkg::BYTE_W-1:0]   check;

  // A delimiter and a zero length byte followed by the expected type byte
  // restart the frame at the type position, whatever the current position.
  assign resync   = (state_i.hist2 == afrc_pkg::DELIMITER) &&
                    (state_i.hist1 == afrc_pkg::LEN_HIGH) &&
                    (rx_byte == expected_type);
  assign pos      = resync ? afrc_pkg::POS_TYPE : state_i.pos;
  assign at_type  = (pos == afrc_pkg::POS_TYPE);
  assign prev_sum = at_type ? '0 : state_i.sum;
  assign sum_new  = prev_sum + rx_byte;
  assign total    = at_type ? ({1'b0, state_i.hist0} + afrc_pkg::FRAME_EXTRA)
                            : state_i.total;
  assign next_pos = {1'b0, pos} + (afrc_pkg::POS_W+1)'(1);
  assign frame_done = (next_pos > (afrc_pkg::POS_W+1)'(afrc_pkg::POS_TYPE)) &&
                      (afrc_pkg::TOTAL_W'(next_pos) == total);
  assign at_limit = (next_pos >= (afrc_pkg::POS_W+1)'(afrc_pkg::MAX_FRAME));
  assign check    = afrc_pkg::CHECK_BASE - prev_sum;

  always_comb begin
    state_o           = state_i;
    state_o.type_byte = at_type ? rx_byte : state_i.type_byte;
    if (frame_done || at_limit) begin
      state_o.hist0 = '0;
      state_o.hist1 = '0;
      state_o.hist2 = '0;
      state_o.pos   = '0;
      state_o.total = '0;
      state_o.sum   = '0;
    end else begin
      state_o.hist2 = state_i.hist1;
      state_o.hist1 = state_i.hist0;
      state_o.hist0 = rx_byte;
      state_o.pos   = next_pos[afrc_pkg::POS_W-1:0];
      state_o.total = total;
      state_o.sum   = sum_new;
    end
  end

  always_comb begin
    result_o.frame_end      = frame_done;
    result_o.frame_valid    = frame_done && (check == rx_byte) &&
                              (state_o.type_byte == expected_type);
    result_o.frame_bytes    = total;
    result_o.byte_position  = state_o.pos;
    result_o.computed_check = frame_done ? check : '0;
  end

endmodule

FILE: src/api_frame_receiver_checksum.sv
// ----------------------------------------------------------------------------
// api_frame_receiver_checksum: API frame receiver with checksum check
// Follows delimiter, length, type, data and checksum bytes of an API frame
// and reports at the last byte whether checksum and frame type matched.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_rx_byte          | input
//   out     | out_valid, out_ready, out_frame_end,    | output
//           | out_frame_valid, out_frame_bytes,       |
//           | out_byte_position, out_computed_check   |
//   cfg     | cfg_valid, cfg_ready, cfg_expected_type | input
//
// One item per cycle unless stalled; its result appears in the cycle after
// acceptance in the output register, fed by the single frame tracking pass.
// A new item is accepted while the output register is empty or being taken.
// Reset clears the frame state and sets the expected type to 0x10.
// The configuration write port is always ready.
// ----------------------------------------------------------------------------
module api_frame_receiver_checksum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [afrc_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_frame_end,
  output logic                          out_frame_valid,
  output logic [afrc_pkg::TOTAL_W-1:0]  out_frame_bytes,
  output logic [afrc_pkg::POS_W-1:0]    out_byte_position,
  output logic [afrc_pkg::BYTE_W-1:0]   out_computed_check,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [afrc_pkg::BYTE_W-1:0]   cfg_expected_type
);

  afrc_pkg::frame_state_t   state_r;
  afrc_pkg::frame_state_t   state_nxt;
  afrc_pkg::frame_result_t  result_r;
  afrc_pkg::frame_result_t  result_nxt;
  logic                     out_valid_r;
  logic [afrc_pkg::BYTE_W-1:0] expected_type_r;
  logic                     in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  afrc_step u_step (
    .state_i       (state_r),
    .rx_byte       (in_rx_byte),
    .expected_type (expected_type_r),
    .state_o       (state_nxt),
    .result_o      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= '0;
      out_valid_r     <= 1'b0;
      expected_type_r <= afrc_pkg::TYPE_RESET;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        expected_type_r <= cfg_expected_type;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_end      = result_r.frame_end;
  assign out_frame_valid    = result_r.frame_valid;
  assign out_frame_bytes    = result_r.frame_bytes;
  assign out_byte_position  = result_r.byte_position;
  assign out_computed_check = result_r.computed_check;

endmodule

FILE: src/afrc_checker.sv
// ----------------------------------------------------------------------------
// afrc_checker: port-level checks of the API frame receiver
// Watches the top level's ports and flags results that break the framing.
// ----------------------------------------------------------------------------
module afrc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_frame_end,
  input logic                          out_frame_valid,
  input logic [afrc_pkg::TOTAL_W-1:0]  out_frame_bytes,
  input logic [afrc_pkg::POS_W-1:0]    out_byte_position,
  input logic [afrc_pkg::BYTE_W-1:0]   out_computed_check
);

  // Every accepted item yields a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // A stalled result holds its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_end) &&
    $stable(out_frame_valid) && $stable(out_frame_bytes) &&
    $stable(out_byte_position) && $stable(out_computed_check))
    else $error("stalled result changed");

  // Only a completed frame can be reported as valid.
  a_valid_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid |-> out_frame_end)
    else $error("frame valid without frame end");

  // Mid-frame results carry no checksum.
  a_check_zero_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |-> out_computed_check == '0)
    else $error("checksum reported before frame end");

  // A completed frame always restarts tracking at the first position.
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_byte_position == '0)
    else $error("frame end without position restart");

endmodule

bind api_frame_receiver_checksum afrc_checker u_afrc_checker (.*);
